@@ hw/rtl/bdll_pkg.sv @@
`timescale 1ns / 1ps

package bdll_pkg;

  localparam int CAPACITY = 256;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LINK_W   = IDX_W + 1;
  localparam int COUNT_W  = 9;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;
  localparam int IN_W     = ((ACTION_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_W    = ((STATUS_W + COUNT_W + 7) / 8) * 8;

  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [VALUE_W-1:0] value_t;

  // null link sits one past the last node
  localparam link_t NIL = LINK_W'(CAPACITY);

  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ADDED     = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_REM_HEAD  = 3'd2,
    STAT_REM_MID   = 3'd3,
    STAT_REM_TAIL  = 3'd4,
    STAT_NOT_FOUND = 3'd5,
    STAT_EMPTY     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_LINK,
    S_REL
  } fsm_t;

endpackage

@@ hw/rtl/bounded_doubly_linked_list.sv @@
`timescale 1ns / 1ps

// Bounded list of up to CAPACITY signed values kept in a node store (value
// memory plus forward-link memory, both registered synchronous reads) with a
// free chain threaded through the forward links. Each input transfer is one
// request: push front, push back, or remove the first node from the head whose
// value matches; each request yields exactly one result transfer with a status
// code and the entry count after the request. Items are handled one at a time.
// A push back onto a non-empty list needs a second link write to the old tail
// before its result. A remove is answered from the head read alone when the
// head matches or the list is empty. Otherwise the walk issues one link/value
// read per cycle on the single memory read port while no result stalls, and a
// hit past the head needs one more step to release the node. The block returns
// to idle after each request before the next is taken. The output register
// lets a finished result wait while the next request is accepted; a stalled
// result holds the datapath. No clearing pass is needed after reset.
module bounded_doubly_linked_list
  import bdll_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // [1:0] action, [33:2] value, rest zero
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [2:0] status, [11:3] entry_count, rest zero
);

  // node store
  value_t val_mem [CAPACITY];
  link_t  nxt_mem [CAPACITY];
  logic [CAPACITY-1:0] nvld_r;   // link entry written since reset

  fsm_t  state_r, state_nxt;
  link_t head_r, head_nxt;
  link_t tail_r, tail_nxt;
  link_t free_r, free_nxt;
  link_t count_r, count_nxt;

  logic [ACTION_W-1:0] act_r, act_nxt;
  value_t  v_r, v_nxt;
  link_t   cur_r, cur_nxt;
  link_t   prev_r, prev_nxt;
  status_t stat_r, stat_nxt;

  logic  rd_en;
  idx_t  rd_addr;
  value_t rdval_r;
  link_t  rdnxt_r;
  idx_t   rdaddr_r;
  logic   rdvld_r;
  link_t  nxt_q;

  logic   val_we, nxt_we;
  idx_t   wr_addr;
  link_t  nxt_wdata;

  logic    emit;
  status_t emit_stat;
  logic    go;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign go         = !out_valid_r || out_tready;

  // unwritten link entries read as their reset value: the free chain i -> i+1
  assign nxt_q = rdvld_r ? rdnxt_r : ({1'b0, rdaddr_r} + LINK_W'(1));

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    free_nxt  = free_r;
    count_nxt = count_r;
    act_nxt   = act_r;
    v_nxt     = v_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    stat_nxt  = stat_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    val_we    = 1'b0;
    nxt_we    = 1'b0;
    wr_addr   = '0;
    nxt_wdata = NIL;
    emit      = 1'b0;
    emit_stat = STAT_ADDED;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt = in_tdata[ACTION_W-1:0];
          v_nxt   = in_tdata[ACTION_W +: VALUE_W];
          rd_en   = 1'b1;
          rd_addr = in_tdata[1] ? head_r[IDX_W-1:0] : free_r[IDX_W-1:0];
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (go) begin
          if (!act_r[1]) begin
            if (count_r == LINK_W'(CAPACITY) || free_r == NIL) begin
              emit = 1'b1;
              emit_stat = STAT_FULL;
              state_nxt = S_IDLE;
            end else begin
              val_we    = 1'b1;
              nxt_we    = 1'b1;
              wr_addr   = free_r[IDX_W-1:0];
              free_nxt  = nxt_q;
              count_nxt = count_r + LINK_W'(1);
              if (act_r == ACT_PUSH_FRONT) begin
                nxt_wdata = (count_r == '0) ? NIL : head_r;
                head_nxt  = free_r;
                if (count_r == '0)
                  tail_nxt = free_r;
                emit = 1'b1;
                emit_stat = STAT_ADDED;
                state_nxt = S_IDLE;
              end else begin
                nxt_wdata = NIL;
                tail_nxt  = free_r;
                if (count_r == '0) begin
                  head_nxt  = free_r;
                  emit      = 1'b1;
                  emit_stat = STAT_ADDED;
                  state_nxt = S_IDLE;
                end else begin
                  // old tail still has to point at the new node
                  cur_nxt   = tail_r;
                  prev_nxt  = free_r;
                  state_nxt = S_LINK;
                end
              end
            end
          end else begin
            if (count_r == '0 || head_r == NIL) begin
              emit = 1'b1;
              emit_stat = STAT_EMPTY;
              state_nxt = S_IDLE;
            end else if (rdval_r == v_r) begin
              head_nxt = (count_r == LINK_W'(1)) ? NIL : nxt_q;
              if (count_r == LINK_W'(1) || nxt_q == NIL)
                tail_nxt = NIL;
              nxt_we    = 1'b1;
              wr_addr   = head_r[IDX_W-1:0];
              nxt_wdata = free_r;
              free_nxt  = head_r;
              count_nxt = count_r - LINK_W'(1);
              emit = 1'b1;
              emit_stat = STAT_REM_HEAD;
              state_nxt = S_IDLE;
            end else begin
              prev_nxt = head_r;
              if (nxt_q == NIL) begin
                emit = 1'b1;
                emit_stat = STAT_NOT_FOUND;
                state_nxt = S_IDLE;
              end else begin
                cur_nxt   = nxt_q;
                rd_en     = 1'b1;
                rd_addr   = nxt_q[IDX_W-1:0];
                state_nxt = S_WALK;
              end
            end
          end
        end
      end

      S_WALK: begin
        // rdval_r / nxt_q belong to node cur_r, prev_r is its predecessor
        if (go) begin
          if (rdval_r == v_r) begin
            nxt_we    = 1'b1;
            wr_addr   = prev_r[IDX_W-1:0];
            nxt_wdata = nxt_q;
            if (tail_r == cur_r) begin
              tail_nxt = prev_r;
              stat_nxt = STAT_REM_TAIL;
            end else begin
              stat_nxt = STAT_REM_MID;
            end
            state_nxt = S_REL;
          end else begin
            prev_nxt = cur_r;
            if (nxt_q == NIL) begin
              emit = 1'b1;
              emit_stat = STAT_NOT_FOUND;
              state_nxt = S_IDLE;
            end else begin
              cur_nxt = nxt_q;
              rd_en   = 1'b1;
              rd_addr = nxt_q[IDX_W-1:0];
            end
          end
        end
      end

      S_REL: begin
        if (go) begin
          nxt_we    = 1'b1;
          wr_addr   = cur_r[IDX_W-1:0];
          nxt_wdata = free_r;
          free_nxt  = cur_r;
          count_nxt = count_r - LINK_W'(1);
          emit      = 1'b1;
          emit_stat = stat_r;
          state_nxt = S_IDLE;
        end
      end

      S_LINK: begin
        if (go) begin
          nxt_we    = 1'b1;
          wr_addr   = cur_r[IDX_W-1:0];
          nxt_wdata = prev_r;
          emit      = 1'b1;
          emit_stat = STAT_ADDED;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= NIL;
      tail_r  <= NIL;
      free_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      free_r  <= free_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    v_r    <= v_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    stat_r <= stat_nxt;
  end

  always_ff @(posedge clk) begin
    if (val_we)
      val_mem[wr_addr] <= v_r;
    if (nxt_we)
      nxt_mem[wr_addr] <= nxt_wdata;
    if (rd_en) begin
      rdval_r  <= val_mem[rd_addr];
      rdnxt_r  <= nxt_mem[rd_addr];
      rdvld_r  <= nvld_r[rd_addr];
      rdaddr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      nvld_r <= '0;
    else if (nxt_we)
      nvld_r[wr_addr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (emit)
      out_valid_r <= 1'b1;
    else if (out_tready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit)
      out_data_r <= {{(OUT_W - STATUS_W - COUNT_W){1'b0}},
                     COUNT_W'(count_nxt), emit_stat};
  end

endmodule

@@ dv/list_checker.sv @@
`timescale 1ns / 1ps

module list_checker
  import bdll_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // [1:0] action, [33:2] value, rest zero
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,  // [2:0] status, [11:3] entry_count, rest zero
  output int               fail_count,
  output int               outstanding,
  output int               stored_count
);

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   entries;
  } list_report_t;

  // shadow copy of the node store
  value_t node_val  [CAPACITY];
  link_t  link_next [CAPACITY];
  link_t  link_prev [CAPACITY];
  link_t  head_ptr;
  link_t  tail_ptr;
  link_t  free_top;
  int     list_count;

  list_report_t report_q[$];

  function automatic void free_node(input link_t n);
    link_next[n[IDX_W-1:0]] = free_top;
    free_top                = n;
    list_count--;
  endfunction

  function automatic status_t predict_request(input logic [ACTION_W-1:0] act,
                                              input value_t v);
    link_t   n;
    link_t   p;
    link_t   pv;
    link_t   nx;
    int      steps;
    status_t st;
    // high action bit selects remove; action 3 aliases remove
    if (!act[1]) begin
      if (list_count >= CAPACITY || free_top >= NIL) return STAT_FULL;
      n                       = free_top;
      free_top                = link_next[n[IDX_W-1:0]];
      node_val[n[IDX_W-1:0]]  = v;
      if (act == ACT_PUSH_FRONT) begin
        link_prev[n[IDX_W-1:0]] = NIL;
        if (list_count == 0 || head_ptr >= NIL) begin
          link_next[n[IDX_W-1:0]] = NIL;
          tail_ptr                = n;
        end else begin
          link_next[n[IDX_W-1:0]]        = head_ptr;
          link_prev[head_ptr[IDX_W-1:0]] = n;
        end
        head_ptr = n;
      end else begin
        link_next[n[IDX_W-1:0]] = NIL;
        if (list_count == 0 || tail_ptr >= NIL) begin
          link_prev[n[IDX_W-1:0]] = NIL;
          head_ptr                = n;
        end else begin
          link_prev[n[IDX_W-1:0]]        = tail_ptr;
          link_next[tail_ptr[IDX_W-1:0]] = n;
        end
        tail_ptr = n;
      end
      list_count++;
      return STAT_ADDED;
    end

    if (list_count == 0 || head_ptr >= NIL) return STAT_EMPTY;

    if (node_val[head_ptr[IDX_W-1:0]] == v) begin
      p = head_ptr;
      if (list_count == 1) begin
        head_ptr = NIL;
        tail_ptr = NIL;
      end else begin
        nx       = link_next[p[IDX_W-1:0]];
        head_ptr = nx;
        if (nx < NIL) link_prev[nx[IDX_W-1:0]] = NIL;
        else tail_ptr = NIL;
      end
      free_node(p);
      return STAT_REM_HEAD;
    end

    p     = link_next[head_ptr[IDX_W-1:0]];
    steps = 0;
    while (p < NIL && steps < CAPACITY && node_val[p[IDX_W-1:0]] != v) begin
      p = link_next[p[IDX_W-1:0]];
      steps++;
    end
    if (p >= NIL || steps >= CAPACITY) return STAT_NOT_FOUND;

    pv = link_prev[p[IDX_W-1:0]];
    nx = link_next[p[IDX_W-1:0]];
    if (pv < NIL) link_next[pv[IDX_W-1:0]] = nx;
    if (tail_ptr == p) begin
      tail_ptr = pv;
      st       = STAT_REM_TAIL;
    end else begin
      if (nx < NIL) link_prev[nx[IDX_W-1:0]] = pv;
      st = STAT_REM_MID;
    end
    free_node(p);
    return st;
  endfunction

  always @(posedge clk) begin : monitor
    list_report_t       rep;
    list_report_t       want;
    status_t            got_status;
    logic [COUNT_W-1:0] got_entries;
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) begin
        node_val[idx_t'(i)]  = '0;
        link_prev[idx_t'(i)] = '0;
        link_next[idx_t'(i)] = link_t'(i + 1);
      end
      head_ptr   = NIL;
      tail_ptr   = NIL;
      free_top   = '0;
      list_count = 0;
      fail_count = 0;
      report_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        rep.status  = predict_request(in_tdata[ACTION_W-1:0], in_tdata[ACTION_W +: VALUE_W]);
        rep.entries = COUNT_W'(list_count);
        report_q.push_back(rep);
      end
      if (out_tvalid && out_tready) begin
        got_status  = status_t'(out_tdata[STATUS_W-1:0]);
        got_entries = out_tdata[STATUS_W +: COUNT_W];
        if (report_q.size() == 0) begin
          $error("unexpected result transfer: status %0d entry_count %0d",
                 got_status, got_entries);
          fail_count++;
        end else begin
          want = report_q.pop_front();
          if (got_status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            fail_count++;
          end
          if (got_entries != want.entries) begin
            $error("entry_count: expected %0d, got %0d", want.entries, got_entries);
            fail_count++;
          end
        end
      end
    end
    outstanding  = report_q.size();
    stored_count = list_count;
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bdll_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_REMOVE     = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE_ALT = 2'd3;  // decodes as remove
  localparam int                  CYCLE_LIMIT    = 1000000;

  localparam value_t V_MIN  = 32'h8000_0000;
  localparam value_t V_MAX  = 32'h7fff_ffff;
  localparam value_t V_ZERO = 32'h0000_0000;
  localparam value_t V_ONES = 32'hffff_ffff;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  int     fail_count;
  int     outstanding;
  int     stored_count;
  int     cycles = 0;
  int     hold_left;
  bit     out_taken;
  bit     quiet;
  value_t value_pool[16];

  bounded_doubly_linked_list i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  list_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .stored_count (stored_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_taken = rst_n && out_tvalid && out_tready;
  end

  // receiver stall: counts down only while a result is presented
  always @(negedge clk) begin
    if (!rst_n) begin
      hold_left  = 0;
      out_tready = 1'b0;
    end else begin
      if (out_taken) hold_left = quiet ? 0 : $urandom_range(0, 6);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        if (out_tvalid) hold_left--;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_request(input logic [ACTION_W-1:0] act, input value_t v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata                      = '0;
    in_tdata[ACTION_W-1:0]        = act;
    in_tdata[ACTION_W +: VALUE_W] = v;
    in_tvalid                     = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic value_t pick_value();
    if ($urandom_range(0, 9) < 7) return value_pool[4'($urandom_range(0, 15))];
    return value_t'($urandom);
  endfunction

  function automatic logic [ACTION_W-1:0] pick_insert();
    return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
  endfunction

  function automatic logic [ACTION_W-1:0] pick_remove();
    return ($urandom_range(0, 3) == 0) ? ACT_REMOVE_ALT : ACT_REMOVE;
  endfunction

  // chunks of mixed traffic; ins_pct weights inserts against removes
  task automatic random_traffic(input int n, input int ins_pct);
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < ins_pct) send_request(pick_insert(), pick_value());
      else send_request(pick_remove(), pick_value());
    end
  endtask

  initial begin
    quiet      = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    value_pool[0] = V_MIN;
    value_pool[1] = V_MAX;
    value_pool[2] = V_ZERO;
    value_pool[3] = V_ONES;
    for (int i = 4; i < 16; i++) value_pool[i] = value_t'($urandom);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty, extremes, every removal position, single node, alias
    send_request(ACT_REMOVE, 32'd5);
    send_request(ACT_PUSH_FRONT, V_MIN);
    send_request(ACT_PUSH_BACK, V_MAX);
    send_request(ACT_PUSH_FRONT, V_ZERO);
    send_request(ACT_PUSH_BACK, V_ONES);
    send_request(ACT_REMOVE, 32'd777);
    send_request(ACT_REMOVE, V_MAX);
    send_request(ACT_REMOVE_ALT, V_ONES);
    send_request(ACT_REMOVE, V_ZERO);
    send_request(ACT_REMOVE, V_MIN);
    send_request(ACT_REMOVE_ALT, V_MIN);
    send_request(ACT_PUSH_BACK, 32'd42);
    send_request(ACT_PUSH_BACK, 32'd42);
    send_request(ACT_PUSH_FRONT, 32'd42);
    send_request(ACT_REMOVE, 32'd42);
    send_request(ACT_PUSH_BACK, 32'h5555_5555);
    send_request(ACT_PUSH_BACK, 32'haaaa_aaaa);
    send_request(ACT_REMOVE_ALT, 32'haaaa_aaaa);
    send_request(ACT_REMOVE, 32'h5555_5555);
    send_request(ACT_REMOVE, 32'd42);
    send_request(ACT_REMOVE, 32'd42);
    send_request(ACT_REMOVE, 32'd42);

    random_traffic(80, 60);

    // let the pipe drain before filling the store
    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);

    quiet = 1'b0;
    while (stored_count < CAPACITY) send_request(pick_insert(), pick_value());
    for (int i = 0; i < 4; i++) send_request(pick_insert(), value_t'($urandom));

    // long walks through a full list: misses run to the end
    random_traffic(60, 15);
    random_traffic(60, 35);
    random_traffic(40, 10);

    in_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (300) @(negedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
